### src/prq_pkg.sv
package prq_pkg;

    localparam int THREAD_SLOTS    = 6;
    localparam int PRIORITY_LEVELS = 16;
    localparam int SLOT_W          = 3;
    localparam int PRIO_W          = 4;
    localparam int RET_W           = 5;
    localparam int STATUS_W        = 2;

    localparam logic [SLOT_W-1:0]       NONE_SLOT = 3'd7;
    localparam logic [PRIO_W-1:0]       PRIO_MAX  = PRIO_W'(PRIORITY_LEVELS - 1);
    localparam logic signed [RET_W-1:0] RET_NONE  = -5'sd1;

    typedef enum logic [2:0] {
        MODE_RUN      = 3'd0,
        MODE_EXIT     = 3'd1,
        MODE_WAIT     = 3'd2,
        MODE_SLEEP    = 3'd3,
        MODE_WAKEUP   = 3'd4,
        MODE_GETID    = 3'd5,
        MODE_CHPRI    = 3'd6,
        MODE_SOFT_ERR = 3'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_SLOT    = 2'd1,
        STATUS_BAD_TARGET = 2'd2
    } status_t;

    typedef struct packed {
        logic [PRIORITY_LEVELS-1:0][SLOT_W-1:0] head;
        logic [PRIORITY_LEVELS-1:0][SLOT_W-1:0] tail;
        logic [THREAD_SLOTS-1:0][SLOT_W-1:0]    link;
        logic [THREAD_SLOTS-1:0][PRIO_W-1:0]    prio;
        logic [THREAD_SLOTS-1:0]                ready;
        logic [THREAD_SLOTS-1:0]                used;
        logic [SLOT_W-1:0]                      running;
        logic                                   halted;
    } state_t;

    typedef struct packed {
        logic signed [RET_W-1:0] return_value;
        logic [SLOT_W-1:0]       next_thread;
        logic [STATUS_W-1:0]     status;
        logic                    system_down;
    } result_t;

    localparam state_t STATE_RESET = '{
        head:    {PRIORITY_LEVELS{NONE_SLOT}},
        tail:    {PRIORITY_LEVELS{NONE_SLOT}},
        link:    {THREAD_SLOTS{NONE_SLOT}},
        prio:    '0,
        ready:   '0,
        used:    '0,
        running: NONE_SLOT,
        halted:  1'b0
    };

    function automatic logic slot_ok(logic [SLOT_W-1:0] s);
        return 32'(s) < THREAD_SLOTS;
    endfunction

    function automatic logic [PRIO_W-1:0] clamp_prio(logic signed [RET_W-1:0] p);
        logic [PRIO_W-1:0] c;
        if (p[RET_W-1]) begin
            c = '0;
        end else if (p[PRIO_W-1:0] > PRIO_MAX) begin
            c = PRIO_MAX;
        end else begin
            c = p[PRIO_W-1:0];
        end
        return c;
    endfunction

    // Appends a slot at the tail of the queue for its priority.
    function automatic state_t enqueue(state_t st, logic [SLOT_W-1:0] s);
        state_t            o;
        logic [PRIO_W-1:0] p;
        o = st;
        if (slot_ok(s)) begin
            if (!st.ready[s]) begin
                p = st.prio[s];
                o.link[s] = NONE_SLOT;
                if (st.tail[p] != NONE_SLOT) begin
                    o.link[st.tail[p]] = s;
                end else begin
                    o.head[p] = s;
                end
                o.tail[p] = s;
                o.ready[s] = 1'b1;
            end
        end
        return o;
    endfunction

    // Takes the running thread off the head of its queue.
    function automatic state_t unlink_running(state_t st);
        state_t            o;
        logic [SLOT_W-1:0] r;
        logic [PRIO_W-1:0] p;
        o = st;
        r = st.running;
        if (slot_ok(r)) begin
            if (st.ready[r]) begin
                p = st.prio[r];
                if (st.head[p] == r) begin
                    o.head[p] = st.link[r];
                    if (st.link[r] == NONE_SLOT) begin
                        o.tail[p] = NONE_SLOT;
                    end
                    o.ready[r] = 1'b0;
                    o.link[r] = NONE_SLOT;
                end
            end
        end
        return o;
    endfunction

    function automatic state_t free_running(state_t st);
        state_t            o;
        logic [SLOT_W-1:0] r;
        o = st;
        r = st.running;
        if (slot_ok(r)) begin
            o.used[r] = 1'b0;
            o.ready[r] = 1'b0;
            o.prio[r] = '0;
            o.link[r] = NONE_SLOT;
        end
        return o;
    endfunction

endpackage

### src/prq_step.sv
module prq_step (
    input  prq_pkg::state_t                   cur,
    input  logic [2:0]                        mode,
    input  logic signed [prq_pkg::RET_W-1:0]  priority_req,
    input  logic [prq_pkg::SLOT_W-1:0]        target_thread,
    output prq_pkg::state_t                   nxt,
    output prq_pkg::result_t                  res
);

    prq_pkg::state_t            st;
    logic                       has_run;
    logic [prq_pkg::SLOT_W-1:0] r;
    logic [prq_pkg::SLOT_W-1:0] free_slot;
    logic                       slot_found;
    logic                       head_found;

    always_comb begin
        st = cur;
        r = cur.running;
        has_run = prq_pkg::slot_ok(r);
        res.return_value = '0;
        res.status = prq_pkg::STATUS_OK;

        st = prq_pkg::unlink_running(st);

        slot_found = 1'b0;
        free_slot = prq_pkg::NONE_SLOT;
        for (int i = 0; i < prq_pkg::THREAD_SLOTS; i++) begin
            if (!slot_found && !st.used[i]) begin
                slot_found = 1'b1;
                free_slot = prq_pkg::SLOT_W'(i);
            end
        end

        case (mode)
            prq_pkg::MODE_RUN: begin
                if (has_run) begin
                    st = prq_pkg::enqueue(st, r);
                end
                if (!slot_found) begin
                    res.return_value = prq_pkg::RET_NONE;
                    res.status = prq_pkg::STATUS_NO_SLOT;
                end else begin
                    st.used[free_slot] = 1'b1;
                    st.ready[free_slot] = 1'b0;
                    st.prio[free_slot] = prq_pkg::clamp_prio(priority_req);
                    st.link[free_slot] = prq_pkg::NONE_SLOT;
                    st = prq_pkg::enqueue(st, free_slot);
                    res.return_value = {2'b00, free_slot};
                end
            end
            prq_pkg::MODE_EXIT, prq_pkg::MODE_SOFT_ERR: begin
                st = prq_pkg::free_running(st);
            end
            prq_pkg::MODE_WAIT: begin
                if (has_run) begin
                    st = prq_pkg::enqueue(st, r);
                end
            end
            prq_pkg::MODE_SLEEP: begin
                st = st;
            end
            prq_pkg::MODE_WAKEUP: begin
                if (has_run) begin
                    st = prq_pkg::enqueue(st, r);
                end
                if (prq_pkg::slot_ok(target_thread) && st.used[target_thread]) begin
                    st = prq_pkg::enqueue(st, target_thread);
                end else begin
                    res.status = prq_pkg::STATUS_BAD_TARGET;
                end
            end
            prq_pkg::MODE_GETID: begin
                if (has_run) begin
                    st = prq_pkg::enqueue(st, r);
                    res.return_value = {2'b00, r};
                end else begin
                    res.return_value = prq_pkg::RET_NONE;
                end
            end
            prq_pkg::MODE_CHPRI: begin
                if (has_run) begin
                    res.return_value = {1'b0, st.prio[r]};
                    if (!priority_req[prq_pkg::RET_W-1]) begin
                        st.prio[r] = prq_pkg::clamp_prio(priority_req);
                    end
                    st = prq_pkg::enqueue(st, r);
                end
            end
            default: begin
                st = st;
            end
        endcase

        head_found = 1'b0;
        st.running = prq_pkg::NONE_SLOT;
        for (int i = 0; i < prq_pkg::PRIORITY_LEVELS; i++) begin
            if (!head_found && st.head[i] != prq_pkg::NONE_SLOT) begin
                head_found = 1'b1;
                st.running = st.head[i];
            end
        end
        if (!head_found) begin
            st.halted = 1'b1;
        end

        res.next_thread = st.running;
        res.system_down = st.halted;
        nxt = st;
    end

endmodule

### src/priority_ready_queue_scheduler.sv
// Hardware thread scheduler with one FIFO ready queue per priority level and
// round robin inside each level. Each input transfer is one system-call event
// of the running thread; each produces exactly one result transfer that gives
// the return value, the thread that runs next, a status code and the sticky
// system-down flag. The block sustains one event per clock as long as the result
// side does not stall: an event is captured in the input register, the whole
// queue update and next-thread selection happen combinationally from that
// register, and the result is captured in the output register, which drives
// m_valid. While a result waits, the input register takes one more event and
// then holds s_ready low until m_ready is high.
module priority_ready_queue_scheduler (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_mode,
    input  logic signed [prq_pkg::RET_W-1:0]   s_priority_req,
    input  logic [prq_pkg::SLOT_W-1:0]         s_target_thread,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [prq_pkg::RET_W-1:0]   m_return_value,
    output logic [prq_pkg::SLOT_W-1:0]         m_next_thread,
    output logic [prq_pkg::STATUS_W-1:0]       m_status,
    output logic                               m_system_down
);

    logic                               in_valid_reg;
    logic [2:0]                         mode_reg;
    logic signed [prq_pkg::RET_W-1:0]   preq_reg;
    logic [prq_pkg::SLOT_W-1:0]         target_reg;
    logic                               out_valid_reg;
    prq_pkg::result_t                   result_reg;
    prq_pkg::result_t                   result_next;
    prq_pkg::state_t                    state_reg;
    prq_pkg::state_t                    state_next;
    logic                               process;

    assign process = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || process;

    prq_step u_step (
        .cur           (state_reg),
        .mode          (mode_reg),
        .priority_req  (preq_reg),
        .target_thread (target_reg),
        .nxt           (state_next),
        .res           (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (process) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            preq_reg <= s_priority_req;
            target_reg <= s_target_thread;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            state_reg <= prq_pkg::STATE_RESET;
        end else if (process) begin
            out_valid_reg <= 1'b1;
            state_reg <= state_next;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_return_value = result_reg.return_value;
    assign m_next_thread = result_reg.next_thread;
    assign m_status = result_reg.status;
    assign m_system_down = result_reg.system_down;

endmodule

### src/prq_checker.sv
module prq_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [prq_pkg::RET_W-1:0]   m_return_value,
    input logic [prq_pkg::SLOT_W-1:0]         m_next_thread,
    input logic [prq_pkg::STATUS_W-1:0]       m_status,
    input logic                               m_system_down
);

    logic       down_seen_reg;
    logic [1:0] pending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_seen_reg <= 1'b0;
            pending_reg <= '0;
        end else begin
            if (m_valid && m_ready && m_system_down) begin
                down_seen_reg <= 1'b1;
            end
            pending_reg <= pending_reg + 2'(s_valid && s_ready) - 2'(m_valid && m_ready);
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_return_value) && $stable(m_next_thread)
            && $stable(m_status) && $stable(m_system_down))
        else $error("Result changed while stalled.");

    a_down_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && down_seen_reg |-> m_system_down)
        else $error("System-down flag cleared after being reported.");

    a_idle_means_down: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_next_thread == prq_pkg::NONE_SLOT |-> m_system_down)
        else $error("No thread runs but system-down is not set.");

    a_no_slot_ret: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == prq_pkg::STATUS_NO_SLOT |-> m_return_value == prq_pkg::RET_NONE)
        else $error("Failed run did not return minus one.");

    a_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 2'd2 && (pending_reg != 2'd0 || !m_valid))
        else $error("Result transfers do not match input transfers.");

endmodule

bind priority_ready_queue_scheduler prq_checker u_prq_checker (.*);

### test/tb_priority_ready_queue_scheduler.sv
`timescale 1ns / 1ps

module tb_priority_ready_queue_scheduler;

    typedef struct {
        prq_pkg::mode_t                   md;
        logic signed [prq_pkg::RET_W-1:0] preq;
        logic [prq_pkg::SLOT_W-1:0]       tgt;
    } syscall_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic [2:0]                         s_mode = prq_pkg::MODE_GETID;
    logic signed [prq_pkg::RET_W-1:0]   s_priority_req = '0;
    logic [prq_pkg::SLOT_W-1:0]         s_target_thread = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic signed [prq_pkg::RET_W-1:0]   m_return_value;
    logic [prq_pkg::SLOT_W-1:0]         m_next_thread;
    logic [prq_pkg::STATUS_W-1:0]       m_status;
    logic                               m_system_down;

    syscall_t          pending_calls[$];
    prq_pkg::result_t  sched_results_due[$];
    syscall_t          call_on_bus;
    int                cycle_count = 0;
    int                mismatches = 0;

    logic [prq_pkg::SLOT_W-1:0] q_first[prq_pkg::PRIORITY_LEVELS];
    logic [prq_pkg::SLOT_W-1:0] q_last[prq_pkg::PRIORITY_LEVELS];
    logic [prq_pkg::SLOT_W-1:0] link_of[prq_pkg::THREAD_SLOTS];
    logic [prq_pkg::PRIO_W-1:0] prio_of[prq_pkg::THREAD_SLOTS];
    logic [prq_pkg::THREAD_SLOTS-1:0] queued;
    logic [prq_pkg::THREAD_SLOTS-1:0] allocated;
    logic [prq_pkg::SLOT_W-1:0] current_thread;
    logic                       went_down;

    priority_ready_queue_scheduler u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_priority_req  (s_priority_req),
        .s_target_thread (s_target_thread),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_return_value  (m_return_value),
        .m_next_thread   (m_next_thread),
        .m_status        (m_status),
        .m_system_down   (m_system_down)
    );

    always #10 aclk = ~aclk;

    function automatic logic take_break();
        return !(cycle_count >= 200 && cycle_count < 450) && ($urandom_range(99) < 17);
    endfunction

    function automatic logic [prq_pkg::PRIO_W-1:0] bound_prio(
        logic signed [prq_pkg::RET_W-1:0] p);
        if (p < 0) begin
            return '0;
        end else if (p > prq_pkg::PRIORITY_LEVELS - 1) begin
            return prq_pkg::PRIO_W'(prq_pkg::PRIORITY_LEVELS - 1);
        end
        return p[prq_pkg::PRIO_W-1:0];
    endfunction

    task automatic append_ready(input logic [prq_pkg::SLOT_W-1:0] s);
        logic [prq_pkg::PRIO_W-1:0] p;
        if (s < prq_pkg::THREAD_SLOTS && !queued[s]) begin
            p = prio_of[s];
            link_of[s] = prq_pkg::NONE_SLOT;
            if (q_last[p] != prq_pkg::NONE_SLOT) begin
                link_of[q_last[p]] = s;
            end else begin
                q_first[p] = s;
            end
            q_last[p] = s;
            queued[s] = 1'b1;
        end
    endtask

    task automatic schedule_syscall(input syscall_t c, output prq_pkg::result_t res);
        logic [prq_pkg::SLOT_W-1:0] r;
        logic [prq_pkg::SLOT_W-1:0] free_slot;
        logic [prq_pkg::PRIO_W-1:0] p;
        logic                       active;
        logic                       found;
        r = current_thread;
        active = r < prq_pkg::THREAD_SLOTS;
        res.return_value = '0;
        res.status = prq_pkg::STATUS_OK;
        free_slot = prq_pkg::NONE_SLOT;

        if (active && queued[r]) begin
            p = prio_of[r];
            if (q_first[p] == r) begin
                q_first[p] = link_of[r];
                if (q_first[p] == prq_pkg::NONE_SLOT) begin
                    q_last[p] = prq_pkg::NONE_SLOT;
                end
                queued[r] = 1'b0;
                link_of[r] = prq_pkg::NONE_SLOT;
            end
        end

        case (c.md)
            prq_pkg::MODE_RUN: begin
                for (int i = prq_pkg::THREAD_SLOTS - 1; i >= 0; i--) begin
                    if (!allocated[i]) begin
                        free_slot = prq_pkg::SLOT_W'(i);
                    end
                end
                if (active) begin
                    append_ready(r);
                end
                if (free_slot == prq_pkg::NONE_SLOT) begin
                    res.return_value = prq_pkg::RET_NONE;
                    res.status = prq_pkg::STATUS_NO_SLOT;
                end else begin
                    allocated[free_slot] = 1'b1;
                    queued[free_slot] = 1'b0;
                    prio_of[free_slot] = bound_prio(c.preq);
                    link_of[free_slot] = prq_pkg::NONE_SLOT;
                    append_ready(free_slot);
                    res.return_value = prq_pkg::RET_W'(free_slot);
                end
            end
            prq_pkg::MODE_EXIT, prq_pkg::MODE_SOFT_ERR: begin
                if (active) begin
                    allocated[r] = 1'b0;
                    queued[r] = 1'b0;
                    prio_of[r] = '0;
                    link_of[r] = prq_pkg::NONE_SLOT;
                end
            end
            prq_pkg::MODE_WAIT: begin
                if (active) begin
                    append_ready(r);
                end
            end
            prq_pkg::MODE_SLEEP: begin
            end
            prq_pkg::MODE_WAKEUP: begin
                if (active) begin
                    append_ready(r);
                end
                if (c.tgt < prq_pkg::THREAD_SLOTS && allocated[c.tgt]) begin
                    append_ready(c.tgt);
                end else begin
                    res.status = prq_pkg::STATUS_BAD_TARGET;
                end
            end
            prq_pkg::MODE_GETID: begin
                if (active) begin
                    append_ready(r);
                    res.return_value = prq_pkg::RET_W'(r);
                end else begin
                    res.return_value = prq_pkg::RET_NONE;
                end
            end
            default: begin
                if (active) begin
                    res.return_value = prq_pkg::RET_W'(prio_of[r]);
                    if (c.preq >= 0) begin
                        prio_of[r] = bound_prio(c.preq);
                    end
                    append_ready(r);
                end
            end
        endcase

        found = 1'b0;
        current_thread = prq_pkg::NONE_SLOT;
        for (int i = 0; i < prq_pkg::PRIORITY_LEVELS; i++) begin
            if (!found && q_first[i] != prq_pkg::NONE_SLOT) begin
                current_thread = q_first[i];
                found = 1'b1;
            end
        end
        if (!found) begin
            went_down = 1'b1;
        end
        res.next_thread = current_thread;
        res.system_down = went_down;
    endtask

    task automatic add_call(input prq_pkg::mode_t md, input int preq, input int tgt);
        syscall_t c;
        c.md = md;
        c.preq = prq_pkg::RET_W'(preq);
        c.tgt = prq_pkg::SLOT_W'(tgt);
        pending_calls.push_back(c);
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge aclk) begin : drive
        prq_pkg::result_t res;
        syscall_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                schedule_syscall(call_on_bus, res);
                sched_results_due.push_back(res);
            end
            if (!s_valid || s_ready) begin
                if (pending_calls.size() != 0 && !take_break()) begin
                    c = pending_calls.pop_front();
                    call_on_bus = c;
                    s_valid <= 1'b1;
                    s_mode <= c.md;
                    s_priority_req <= c.preq;
                    s_target_thread <= c.tgt;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= aresetn && !take_break();
    end

    always @(posedge aclk) begin : check
        prq_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (sched_results_due.size() == 0) begin
                $error("result transfer with no pending expectation");
                mismatches++;
            end else begin
                want = sched_results_due.pop_front();
                if (m_return_value !== want.return_value) begin
                    $error("return_value: expected %0d, actual %0d",
                           want.return_value, m_return_value);
                    mismatches++;
                end
                if (m_next_thread !== want.next_thread) begin
                    $error("next_thread: expected %0d, actual %0d",
                           want.next_thread, m_next_thread);
                    mismatches++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    mismatches++;
                end
                if (m_system_down !== want.system_down) begin
                    $error("system_down: expected %0d, actual %0d",
                           want.system_down, m_system_down);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int pick;
        for (int i = 0; i < prq_pkg::PRIORITY_LEVELS; i++) begin
            q_first[i] = prq_pkg::NONE_SLOT;
            q_last[i] = prq_pkg::NONE_SLOT;
        end
        for (int i = 0; i < prq_pkg::THREAD_SLOTS; i++) begin
            link_of[i] = prq_pkg::NONE_SLOT;
            prio_of[i] = '0;
        end
        queued = '0;
        allocated = '0;
        current_thread = prq_pkg::NONE_SLOT;
        went_down = 1'b0;

        // The first thread starts from a run with nobody running.
        add_call(prq_pkg::MODE_RUN, -16, 0);
        add_call(prq_pkg::MODE_RUN, 15, 7);
        add_call(prq_pkg::MODE_RUN, 5, 0);
        add_call(prq_pkg::MODE_RUN, 0, 0);
        add_call(prq_pkg::MODE_GETID, 0, 0);
        add_call(prq_pkg::MODE_WAIT, 0, 0);
        add_call(prq_pkg::MODE_RUN, 7, 0);
        add_call(prq_pkg::MODE_RUN, 3, 0);
        add_call(prq_pkg::MODE_RUN, 1, 0);
        add_call(prq_pkg::MODE_CHPRI, -1, 0);
        add_call(prq_pkg::MODE_CHPRI, 15, 0);
        add_call(prq_pkg::MODE_WAKEUP, 0, 7);
        add_call(prq_pkg::MODE_WAKEUP, 0, 6);
        add_call(prq_pkg::MODE_SLEEP, 0, 0);
        add_call(prq_pkg::MODE_WAKEUP, 0, 2);
        add_call(prq_pkg::MODE_EXIT, 0, 0);
        add_call(prq_pkg::MODE_SOFT_ERR, 0, 0);
        for (int i = 0; i < 5; i++) begin
            add_call(prq_pkg::MODE_SLEEP, 0, 0);
        end
        add_call(prq_pkg::MODE_GETID, 0, 0);
        add_call(prq_pkg::MODE_CHPRI, 4, 0);
        add_call(prq_pkg::MODE_WAKEUP, 0, 3);
        add_call(prq_pkg::MODE_RUN, -1, 5);

        for (int n = 0; n < 600; n++) begin
            pick = $urandom_range(99);
            add_call(prq_pkg::mode_t'(pick < 22 ? prq_pkg::MODE_RUN :
                                      pick < 32 ? prq_pkg::MODE_EXIT :
                                      pick < 44 ? prq_pkg::MODE_WAIT :
                                      pick < 54 ? prq_pkg::MODE_SLEEP :
                                      pick < 72 ? prq_pkg::MODE_WAKEUP :
                                      pick < 80 ? prq_pkg::MODE_GETID :
                                      pick < 92 ? prq_pkg::MODE_CHPRI :
                                      prq_pkg::MODE_SOFT_ERR),
                     int'($signed(prq_pkg::RET_W'($urandom_range(31)))),
                     $urandom_range(99) < 80 ? $urandom_range(5) : $urandom_range(7));
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_calls.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (sched_results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
